// ===== sv/bdpd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the button debounce and press detector.
// Used by bdpd_lane, bdpd_merge and button_debounce_press_detector.
package bdpd_pkg;

  localparam int MAX_BUTTONS      = 3;
  localparam int NUM_BUTTONS_DEF  = 3;
  localparam int TIME_W           = 32;
  localparam int CFG_W            = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int CODE_W           = 3;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

  // Opcodes of an input item.
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_FETCH  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_ONE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TWO  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_THREE = 2'd3;

  // Event codes: short press of button i is SHORT_BASE + i, long press LONG_BASE + i.
  localparam logic [CODE_W-1:0] EV_NONE    = 3'd0;
  localparam int                SHORT_BASE = 1;
  localparam int                LONG_BASE  = 4;

  typedef enum logic [2:0] {
    PS_RELEASED = 3'b001,
    PS_PRESSED  = 3'b010,
    PS_HELD     = 3'b100
  } press_state_t;

  typedef enum logic [1:0] {
    SLOT_NONE  = 2'd0,
    SLOT_SHORT = 2'd1,
    SLOT_LONG  = 2'd2
  } slot_t;

  typedef struct packed {
    logic upd;   // an update item is applied this cycle
    logic clr;   // a fetch takes this button's event
  } lane_ctl_t;

  typedef struct packed {
    slot_t slot;      // event slot before this cycle
    logic  held_nxt;  // debounced pressed or long-held after this cycle
  } lane_stat_t;

endpackage

// ===== sv/bdpd_lane.sv =====
`timescale 1ns / 1ps
// One button lane: debounce, press classification and the event slot.
// Depends on bdpd_pkg.
module bdpd_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bdpd_pkg::lane_ctl_t           ctl_i,
  input  logic [bdpd_pkg::TIME_W-1:0]   now_i,
  input  logic                          level_i,
  input  logic [bdpd_pkg::CFG_W-1:0]    debounce_i,
  input  logic [bdpd_pkg::CFG_W-1:0]    long_press_i,
  output bdpd_pkg::lane_stat_t          stat_o
);

  logic                          raw_r, raw_nxt;
  logic                          pend_r, pend_nxt;
  logic [bdpd_pkg::TIME_W-1:0]   ct_r, ct_nxt;
  bdpd_pkg::press_state_t        ps_r, ps_nxt;
  bdpd_pkg::slot_t               slot_r, slot_nxt;

  logic                          pressed;
  logic                          chg;
  logic                          pend_t;
  logic [bdpd_pkg::TIME_W-1:0]   age;
  logic                          acc;
  bdpd_pkg::press_state_t        ps_a;
  bdpd_pkg::slot_t               slot_a;

  assign pressed = ~level_i;
  assign chg     = pressed != raw_r;
  assign pend_t  = pend_r ^ chg;
  // A change seen in this item restarts the age at zero.
  assign age     = chg ? '0 : (now_i - ct_r);
  assign acc     = pend_t && (age > {{(bdpd_pkg::TIME_W-bdpd_pkg::CFG_W){1'b0}}, debounce_i});

  always_comb begin
    ps_a   = ps_r;
    slot_a = slot_r;
    if (acc) begin
      if (!pressed && ps_r == bdpd_pkg::PS_PRESSED) begin
        slot_a = bdpd_pkg::SLOT_SHORT;
      end
      ps_a = pressed ? bdpd_pkg::PS_PRESSED : bdpd_pkg::PS_RELEASED;
    end

    raw_nxt  = raw_r;
    pend_nxt = pend_r;
    ct_nxt   = ct_r;
    ps_nxt   = ps_r;
    slot_nxt = slot_r;
    if (ctl_i.upd) begin
      raw_nxt  = pressed;
      ct_nxt   = chg ? now_i : ct_r;
      pend_nxt = acc ? 1'b0 : pend_t;
      ps_nxt   = ps_a;
      slot_nxt = slot_a;
      if (ps_a == bdpd_pkg::PS_PRESSED &&
          age > {{(bdpd_pkg::TIME_W-bdpd_pkg::CFG_W){1'b0}}, long_press_i}) begin
        ps_nxt   = bdpd_pkg::PS_HELD;
        slot_nxt = bdpd_pkg::SLOT_LONG;
      end
    end else if (ctl_i.clr) begin
      slot_nxt = bdpd_pkg::SLOT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r  <= 1'b0;
      pend_r <= 1'b0;
      ct_r   <= '0;
      ps_r   <= bdpd_pkg::PS_RELEASED;
      slot_r <= bdpd_pkg::SLOT_NONE;
    end else begin
      raw_r  <= raw_nxt;
      pend_r <= pend_nxt;
      ct_r   <= ct_nxt;
      ps_r   <= ps_nxt;
      slot_r <= slot_nxt;
    end
  end

  assign stat_o.slot     = slot_r;
  assign stat_o.held_nxt = ps_nxt != bdpd_pkg::PS_RELEASED;

  // A fetch that takes this button's event leaves the slot empty.
  a_clr_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_i.clr && !ctl_i.upd |=> slot_r == bdpd_pkg::SLOT_NONE)
    else $error("event slot not cleared after fetch");

  // A short event is only posted by the release of a plain press.
  a_short_from_press: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_i.upd && slot_r != bdpd_pkg::SLOT_SHORT && slot_nxt == bdpd_pkg::SLOT_SHORT
    |-> ps_r == bdpd_pkg::PS_PRESSED && !pressed)
    else $error("short event without a released plain press");

endmodule

// ===== sv/bdpd_merge.sv =====
`timescale 1ns / 1ps
// Merging stage: on a fetch, picks the pending event of the lowest-numbered button and
// gathers the pressed mask from all lanes. Depends on bdpd_pkg.
module bdpd_merge #(
  parameter int NUM_BUTTONS = bdpd_pkg::NUM_BUTTONS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fetch_i,
  input  bdpd_pkg::lane_stat_t             stat_i [NUM_BUTTONS],
  output logic [NUM_BUTTONS-1:0]           clr_o,
  output logic [bdpd_pkg::CODE_W-1:0]      code_o,
  output logic [bdpd_pkg::MAX_BUTTONS-1:0] mask_o
);

  logic                        found;
  logic [bdpd_pkg::CODE_W-1:0] code;

  always_comb begin
    found  = 1'b0;
    code   = bdpd_pkg::EV_NONE;
    clr_o  = '0;
    mask_o = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      mask_o[i] = stat_i[i].held_nxt;
      if (!found && stat_i[i].slot != bdpd_pkg::SLOT_NONE) begin
        found    = 1'b1;
        clr_o[i] = fetch_i;
        code     = (stat_i[i].slot == bdpd_pkg::SLOT_SHORT) ?
                   bdpd_pkg::CODE_W'(bdpd_pkg::SHORT_BASE + i) :
                   bdpd_pkg::CODE_W'(bdpd_pkg::LONG_BASE + i);
      end
    end
    code_o = fetch_i ? code : bdpd_pkg::EV_NONE;
  end

  // A fetch takes at most one event.
  a_one_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(clr_o))
    else $error("fetch clears more than one event slot");

endmodule

// ===== sv/button_debounce_press_detector.sv =====
`timescale 1ns / 1ps
// Top level of the button debounce and press detector: configuration registers,
// one lane per button, the merging stage and a two-entry output buffer.
// Depends on bdpd_pkg, bdpd_lane and bdpd_merge.
//
//  channel | signals                                                        | role
//  input   | in_valid, in_stall, in_opcode, in_now_ms, in_button_levels     | item in
//  result  | out_valid, out_stall, out_event_code, out_pressed_mask         | one per item
//  config  | cfg_we, cfg_index, cfg_data                                    | register writes
//
// An item is worked in the cycle of its transfer and its result is registered in the output
// register, or in the skid register while the output stalls; one item per cycle is sustained
// without stalls. A result stall parks one result in the skid register; in_stall is that
// registered skid-full flag, so input stops the cycle after an item meets a stalled output.
// Reset is synchronous: all buttons released, no pending change, no events, and
// the registers at their defaults (debounce 50 ms, long press 1000 ms).
module button_debounce_press_detector #(
  parameter int NUM_BUTTONS = bdpd_pkg::NUM_BUTTONS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_opcode,
  input  logic [bdpd_pkg::TIME_W-1:0]        in_now_ms,
  input  logic [bdpd_pkg::MAX_BUTTONS-1:0]   in_button_levels,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bdpd_pkg::CODE_W-1:0]        out_event_code,
  output logic [bdpd_pkg::MAX_BUTTONS-1:0]   out_pressed_mask,
  input  logic                               cfg_we,
  input  logic [bdpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bdpd_pkg::CFG_W-1:0]         cfg_data
);

  logic [bdpd_pkg::CFG_W-1:0] debounce_r;
  logic [bdpd_pkg::CFG_W-1:0] long_press_r [bdpd_pkg::MAX_BUTTONS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= bdpd_pkg::DEBOUNCE_RST;
      for (int i = 0; i < bdpd_pkg::MAX_BUTTONS; i++) begin
        long_press_r[i] <= bdpd_pkg::LONG_PRESS_RST;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdpd_pkg::CFG_DEBOUNCE:   debounce_r      <= cfg_data;
        bdpd_pkg::CFG_LONG_ONE:   long_press_r[0] <= cfg_data;
        bdpd_pkg::CFG_LONG_TWO:   long_press_r[1] <= cfg_data;
        bdpd_pkg::CFG_LONG_THREE: long_press_r[2] <= cfg_data;
      endcase
    end
  end

  // Handshake and output buffer.
  logic in_fire, out_fire, out_free;
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  logic [bdpd_pkg::CODE_W-1:0]      out_code_r, out_code_nxt, skid_code_r, skid_code_nxt;
  logic [bdpd_pkg::MAX_BUTTONS-1:0] out_mask_r, out_mask_nxt, skid_mask_r, skid_mask_nxt;

  logic [bdpd_pkg::CODE_W-1:0]      res_code;
  logic [bdpd_pkg::MAX_BUTTONS-1:0] res_mask;
  logic                             fetch;
  logic [NUM_BUTTONS-1:0]           clr;
  bdpd_pkg::lane_stat_t             stat [NUM_BUTTONS];

  assign in_fire  = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;
  assign out_free = out_fire || !out_valid_r;
  assign fetch    = in_fire && (in_opcode == bdpd_pkg::OP_FETCH);

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    bdpd_pkg::lane_ctl_t ctl;
    assign ctl.upd = in_fire && (in_opcode == bdpd_pkg::OP_UPDATE);
    assign ctl.clr = clr[g];
    bdpd_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl_i        (ctl),
      .now_i        (in_now_ms),
      .level_i      (in_button_levels[g]),
      .debounce_i   (debounce_r),
      .long_press_i (long_press_r[g]),
      .stat_o       (stat[g])
    );
  end

  bdpd_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .fetch_i (fetch),
    .stat_i  (stat),
    .clr_o   (clr),
    .code_o  (res_code),
    .mask_o  (res_mask)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_code_nxt   = out_code_r;
    out_mask_nxt   = out_mask_r;
    skid_valid_nxt = skid_valid_r;
    skid_code_nxt  = skid_code_r;
    skid_mask_nxt  = skid_mask_r;
    if (out_free) begin
      if (skid_valid_r) begin
        // The waiting transfer moves up; no item is taken in this cycle.
        out_valid_nxt  = 1'b1;
        out_code_nxt   = skid_code_r;
        out_mask_nxt   = skid_mask_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_fire;
        out_code_nxt  = res_code;
        out_mask_nxt  = res_mask;
      end
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_code_nxt  = res_code;
      skid_mask_nxt  = res_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_code_r  <= out_code_nxt;
    out_mask_r  <= out_mask_nxt;
    skid_code_r <= skid_code_nxt;
    skid_mask_r <= skid_mask_nxt;
  end

  assign in_stall         = skid_valid_r;
  assign out_valid        = out_valid_r;
  assign out_event_code   = out_code_r;
  assign out_pressed_mask = out_mask_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_code_r <= 3'd6)
    else $error("event code out of range");

  a_update_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_opcode == bdpd_pkg::OP_UPDATE && !out_valid_r
    |=> out_code_r == bdpd_pkg::EV_NONE)
    else $error("update item produced an event code");

endmodule
